FILE: hdl/rsp_pkg.sv
// shared types, constants and gf(2^8) helpers for the reed-solomon parity block
// no dependencies
package rsp_pkg;

    localparam int RSP_MAX_PARITY = 32;
    localparam int RSP_DEG_W      = $clog2(RSP_MAX_PARITY + 1);
    localparam int RSP_CFG_W      = 6;
    localparam int RSP_RESET_DEG  = 10;

    // low byte of the reduction polynomial 0x11d
    localparam logic [7:0] RSP_GF_POLY = 8'h1D;

    typedef logic [7:0] gf_t;
    typedef gf_t [RSP_MAX_PARITY-1:0] gf_vec_t;
    typedef logic [RSP_DEG_W-1:0] deg_t;

    // control from the top level into the division register
    typedef struct packed {
        logic beat;      // data beat accepted
        logic eom;       // beat closes the message
        logic clear;     // config write
    } rsp_lfsr_ctrl_t;

    function automatic gf_t rsp_gf_mul(gf_t a, gf_t b);
        gf_t z;
        z = '0;
        for (int i = 7; i >= 0; i--)
        begin
            z = {z[6:0], 1'b0} ^ (z[7] ? RSP_GF_POLY : 8'h00);
            z = z ^ (b[i] ? a : 8'h00);
        end
        return z;
    endfunction

    function automatic gf_t rsp_xtime(gf_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? RSP_GF_POLY : 8'h00);
    endfunction

    function automatic deg_t rsp_clamp(logic [RSP_CFG_W-1:0] v);
        if (v == '0)
            return deg_t'(1);
        else if (int'(v) > RSP_MAX_PARITY)
            return deg_t'(RSP_MAX_PARITY);
        else
            return deg_t'(v);
    endfunction

    // starting polynomial for the build: monic term at index deg-1
    function automatic gf_vec_t rsp_seed(deg_t deg);
        gf_vec_t g;
        for (int j = 0; j < RSP_MAX_PARITY; j++)
        begin
            g[j] = (j == int'(deg) - 1) ? 8'h01 : 8'h00;
        end
        return g;
    endfunction

endpackage

FILE: hdl/rsp_genpoly.sv
// generator polynomial builder: one factor (x + 2^i) per cycle
// depends on rsp_pkg
module rsp_genpoly import rsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  deg_t    deg,
    output gf_vec_t coeffs,
    output logic    busy
);

    gf_vec_t coeff_reg, coeff_next;
    gf_t     root_reg, root_next;
    deg_t    count_reg, count_next;

    always_comb
    begin
        coeff_next = coeff_reg;
        root_next  = root_reg;
        count_next = count_reg;
        if (start)
        begin
            coeff_next = rsp_seed(deg);
            root_next  = 8'h01;
            count_next = deg;
        end
        else if (count_reg != '0)
        begin
            for (int j = 0; j < RSP_MAX_PARITY - 1; j++)
            begin
                coeff_next[j] = rsp_gf_mul(coeff_reg[j], root_reg) ^ coeff_reg[j+1];
            end
            coeff_next[RSP_MAX_PARITY-1] = rsp_gf_mul(coeff_reg[RSP_MAX_PARITY-1], root_reg);
            root_next  = rsp_xtime(root_reg);
            count_next = count_reg - deg_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_reg <= rsp_seed(deg_t'(RSP_RESET_DEG));
            root_reg  <= 8'h01;
            count_reg <= deg_t'(RSP_RESET_DEG);
        end
        else
        begin
            coeff_reg <= coeff_next;
            root_reg  <= root_next;
            count_reg <= count_next;
        end
    end

    assign coeffs = coeff_reg;
    assign busy   = (count_reg != '0);

endmodule

FILE: hdl/rsp_lfsr.sv
// division register in lfsr form, all taps updated together
// depends on rsp_pkg
module rsp_lfsr import rsp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  rsp_lfsr_ctrl_t ctrl,
    input  gf_t            data_byte,
    input  gf_vec_t        coeffs,
    output gf_vec_t        remainder_next
);

    gf_vec_t rem_reg, rem_next;
    gf_t     feedback;

    // entries at or above the degree stay zero, so the top shifts in zero
    always_comb
    begin
        feedback = data_byte ^ rem_reg[0];
        for (int j = 0; j < RSP_MAX_PARITY - 1; j++)
        begin
            remainder_next[j] = rem_reg[j+1] ^ rsp_gf_mul(coeffs[j], feedback);
        end
        remainder_next[RSP_MAX_PARITY-1] = rsp_gf_mul(coeffs[RSP_MAX_PARITY-1], feedback);

        rem_next = rem_reg;
        if (ctrl.clear)
            rem_next = '0;
        else if (ctrl.beat)
            rem_next = ctrl.eom ? '0 : remainder_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

endmodule

FILE: hdl/rsp_outbuf.sv
// parity output shift register, one beat per parity byte
// depends on rsp_pkg
module rsp_outbuf import rsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  gf_vec_t load_bytes,
    input  deg_t    deg,
    input  logic    parity_ready,
    output logic    parity_valid,
    output gf_t     parity_byte,
    output logic    last_parity,
    output logic    free
);

    gf_vec_t buf_reg, buf_next;
    deg_t    cnt_reg, cnt_next;
    logic    out_beat;

    assign out_beat = parity_valid && parity_ready;

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            buf_next = load_bytes;
            cnt_next = deg;
        end
        else if (out_beat)
        begin
            for (int j = 0; j < RSP_MAX_PARITY - 1; j++)
            begin
                buf_next[j] = buf_reg[j+1];
            end
            buf_next[RSP_MAX_PARITY-1] = 8'h00;
            cnt_next = cnt_reg - deg_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign parity_valid = (cnt_reg != '0);
    assign parity_byte  = buf_reg[0];
    assign last_parity  = (cnt_reg == deg_t'(1));
    assign free         = (cnt_reg == '0) || ((cnt_reg == deg_t'(1)) && parity_ready);

endmodule

FILE: hdl/reed_solomon_parity_gf256.sv
// top level of the systematic reed-solomon parity generator over gf(2^8)
// depends on rsp_pkg, rsp_genpoly, rsp_lfsr, rsp_outbuf
//
// channels
//   data   : data_valid / data_ready carry data_byte and end_of_message, one
//            message byte per beat; end_of_message marks the final byte
//   parity : parity_valid / parity_ready carry parity_byte and last_parity,
//            highest-order remainder byte first, last_parity on the final one
//   cfg    : cfg_valid / cfg_ready carry cfg_data, the parity count; values
//            below 1 saturate to 1, above the maximum to the maximum
// throughput: one data beat per cycle while data_ready is high; the
//   division register updates all taps together
// latency: the first parity beat is offered the cycle after the final data
//   beat; parity_count beats follow, one per cycle while parity_ready is high
// the next message streams in while parity is still drained; a final byte
//   waits only on a generator build or the previous block's unsent parity
// a cfg write clears the division register and rebuilds the generator, one
//   factor per cycle, parity_count factors; data and cfg are held off then
// reset: degree 10; data_ready stays low while the generator is built
// stall: when parity_ready is low the current parity beat holds
module reed_solomon_parity_gf256 import rsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 data_valid,
    output logic                 data_ready,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_message,
    output logic                 parity_valid,
    input  logic                 parity_ready,
    output logic [7:0]           parity_byte,
    output logic                 last_parity,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RSP_CFG_W-1:0] cfg_data
);

    deg_t           deg_reg, deg_next;
    logic           gen_busy;
    logic           out_free;
    logic           cfg_beat;
    logic           data_beat;
    gf_vec_t        coeffs;
    gf_vec_t        remainder_next;
    rsp_lfsr_ctrl_t lfsr_ctrl;

    assign cfg_ready  = !gen_busy;
    assign cfg_beat   = cfg_valid && cfg_ready;

    // a final byte needs the parity buffer empty, or emptying this cycle
    assign data_ready = !gen_busy && (!end_of_message || out_free);
    assign data_beat  = data_valid && data_ready;

    assign deg_next = cfg_beat ? rsp_clamp(cfg_data) : deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deg_reg <= deg_t'(RSP_RESET_DEG);
        else
            deg_reg <= deg_next;
    end

    assign lfsr_ctrl.beat  = data_beat;
    assign lfsr_ctrl.eom   = end_of_message;
    assign lfsr_ctrl.clear = cfg_beat;

    rsp_genpoly u_genpoly
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_beat),
        .deg    (deg_next),
        .coeffs (coeffs),
        .busy   (gen_busy)
    );

    rsp_lfsr u_lfsr
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (lfsr_ctrl),
        .data_byte      (data_byte),
        .coeffs         (coeffs),
        .remainder_next (remainder_next)
    );

    // the remainder after the final byte goes straight to the parity buffer
    rsp_outbuf u_outbuf
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (data_beat && end_of_message),
        .load_bytes   (remainder_next),
        .deg          (deg_reg),
        .parity_ready (parity_ready),
        .parity_valid (parity_valid),
        .parity_byte  (parity_byte),
        .last_parity  (last_parity),
        .free         (out_free)
    );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for reed_solomon_parity_gf256: directed table, then random messages
// depends on rsp_pkg and the reed_solomon_parity_gf256 rtl
// predicts parity with its own gf(2^8) division
module tb;
    import rsp_pkg::*;

    // low byte of x^8 + x^4 + x^3 + x^2 + 1
    localparam logic [7:0] GF_REDUCE   = 8'h1D;
    localparam int         ITEMS_TOTAL = 260;
    localparam int         QUIET_TAIL  = 40;
    localparam int         RESET_COUNT = 10;

    typedef enum logic {ROW_DATA, ROW_CFG} row_kind_t;

    // one row of the directed table; typed rows carry a parity value read straight off the math
    typedef struct {
        row_kind_t  kind;
        logic [7:0] value;
        logic       eom;
        logic       typed;
        logic [7:0] typed_val;
    } stim_row_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } parity_beat_t;

    localparam int N_ROWS = 23;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 data_valid = 1'b0;
    logic                 data_ready;
    logic [7:0]           data_byte = 8'h00;
    logic                 end_of_message = 1'b0;
    logic                 parity_valid;
    logic                 parity_ready = 1'b0;
    logic [7:0]           parity_byte;
    logic                 last_parity;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [RSP_CFG_W-1:0] cfg_data = '0;

    // predictor state: generator taps and division register at the current degree
    logic [7:0]   gen_tap [RSP_MAX_PARITY];
    logic [7:0]   div_reg [RSP_MAX_PARITY];
    int           cur_deg;

    parity_beat_t parity_due [$];
    parity_beat_t got_due;
    stim_row_t    dir_rows [N_ROWS];

    int  beats_sent = 0;
    int  blocks_sent = 0;
    int  parity_checked = 0;
    int  cfg_writes = 0;
    int  mismatches = 0;
    int  stall_left = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_stall_en = 1'b0;
    bit  quiet = 1'b0;
    bit  deg_seen [RSP_MAX_PARITY+1];

    reed_solomon_parity_gf256 u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_valid     (data_valid),
        .data_ready     (data_ready),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .parity_valid   (parity_valid),
        .parity_ready   (parity_ready),
        .parity_byte    (parity_byte),
        .last_parity    (last_parity),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shift-and-add product in gf(2^8): walk b from the lsb, doubling a each step
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        int         i;
        acc = 8'h00;
        x = a;
        for (i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? GF_REDUCE : 8'h00);
        end
        return acc;
    endfunction

    // rebuild the generator taps from a raw count; a write also drops any open message
    task automatic rs_build_generator(input logic [RSP_CFG_W-1:0] raw);
        logic [7:0] root;
        int         i;
        int         j;
        if (raw == '0)
            cur_deg = 1;
        else if (int'(raw) > RSP_MAX_PARITY)
            cur_deg = RSP_MAX_PARITY;
        else
            cur_deg = int'(raw);
        deg_seen[cur_deg] = 1'b1;
        for (j = 0; j < RSP_MAX_PARITY; j++)
        begin
            gen_tap[j] = 8'h00;
            div_reg[j] = 8'h00;
        end
        // multiply in (x + 2^i) one root at a time, monic term kept implicit
        gen_tap[cur_deg-1] = 8'h01;
        root = 8'h01;
        for (i = 0; i < cur_deg; i++)
        begin
            for (j = 0; j < cur_deg; j++)
            begin
                gen_tap[j] = gf_times(gen_tap[j], root);
                if (j + 1 < cur_deg)
                    gen_tap[j] ^= gen_tap[j+1];
            end
            root = gf_times(root, 8'h02);
        end
    endtask

    // one lfsr step; on the final byte queue the remainder as parity beats
    task automatic rs_divide_byte(input logic [7:0] b, input logic eom,
                                  input logic typed, input logic [7:0] typed_val);
        logic [7:0]   fb;
        parity_beat_t pb;
        int           j;
        fb = b ^ div_reg[0];
        for (j = 0; j + 1 < cur_deg; j++)
            div_reg[j] = div_reg[j+1];
        div_reg[cur_deg-1] = 8'h00;
        for (j = 0; j < cur_deg; j++)
            div_reg[j] ^= gf_times(gen_tap[j], fb);
        if (eom)
        begin
            for (j = 0; j < cur_deg; j++)
            begin
                pb.value = typed ? typed_val : div_reg[j];
                pb.last  = (j == cur_deg - 1);
                parity_due.insert(parity_due.size(), pb);
                div_reg[j] = 8'h00;
            end
            blocks_sent++;
        end
    endtask

    // one data beat, with an optional idle burst in front of it; valid stays up after the beat
    task automatic send_byte(input logic [7:0] b, input logic eom,
                             input logic typed, input logic [7:0] typed_val);
        if (tx_idle_en && !quiet && $urandom_range(0, 3) == 0)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        data_valid     <= 1'b1;
        data_byte      <= b;
        end_of_message <= eom;
        do @(posedge clk); while (!data_ready);
        rs_divide_byte(b, eom, typed, typed_val);
        beats_sent++;
        if (beats_sent >= ITEMS_TOTAL - QUIET_TAIL)
            quiet = 1'b1;
    endtask

    // register write only once the block has drained: parity out, last beat absorbed
    task automatic write_parity_count(input logic [RSP_CFG_W-1:0] v);
        data_valid <= 1'b0;
        while (parity_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rs_build_generator(v);
        cfg_writes++;
    endtask

    // parity side back-pressure: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            parity_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (rx_stall_en && !quiet && $urandom_range(0, 5) == 0)
        begin
            parity_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end
        else
        begin
            parity_ready <= 1'b1;
        end
    end

    // scoreboard: each parity beat against the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && parity_valid && parity_ready)
        begin
            if (parity_due.size() == 0)
            begin
                $display("%0t: parity beat with nothing due: expected none, %s %02h last %0b",
                         $time, "actual byte", parity_byte, last_parity);
                mismatches++;
            end
            else
            begin
                got_due = parity_due.pop_front();
                parity_checked++;
                if (parity_byte !== got_due.value)
                begin
                    $display("%0t: parity_byte mismatch: expected %02h actual %02h",
                             $time, got_due.value, parity_byte);
                    mismatches++;
                end
                if (last_parity !== got_due.last)
                begin
                    $display("%0t: last_parity mismatch: expected %0b actual %0b",
                             $time, got_due.last, last_parity);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [7:0]           b;
        logic [RSP_CFG_W-1:0] v;
        int                   r;
        int                   n_msgs;
        int                   len;
        int                   m;
        int                   k;
        bit                   broken;

        // directed rows: extremes of the bytes, degree saturation both ways, dropped partial
        dir_rows = '{
            '{ROW_DATA, 8'h00, 1'b1, 1'b1, 8'h00},  // zero message after reset gives zero parity
            '{ROW_DATA, 8'hFF, 1'b0, 1'b0, 8'h00},
            '{ROW_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_DATA, 8'h80, 1'b1, 1'b0, 8'h00},
            '{ROW_DATA, 8'h01, 1'b1, 1'b0, 8'h00},  // lone one: parity is the generator taps
            '{ROW_DATA, 8'h55, 1'b0, 1'b0, 8'h00},  // left open, dropped by the write below
            '{ROW_CFG,  8'h00, 1'b0, 1'b0, 8'h00},  // zero count saturates to one
            '{ROW_DATA, 8'hFF, 1'b1, 1'b1, 8'hFF},  // degree one: parity is the xor of the bytes
            '{ROW_DATA, 8'hA5, 1'b0, 1'b0, 8'h00},
            '{ROW_DATA, 8'h5A, 1'b1, 1'b1, 8'hFF},
            '{ROW_CFG,  8'h3F, 1'b0, 1'b0, 8'h00},  // all ones saturates to the maximum
            '{ROW_DATA, 8'hFF, 1'b1, 1'b0, 8'h00},
            '{ROW_DATA, 8'h00, 1'b1, 1'b1, 8'h00},
            '{ROW_CFG,  8'h21, 1'b0, 1'b0, 8'h00},  // one past the maximum
            '{ROW_DATA, 8'h12, 1'b0, 1'b0, 8'h00},
            '{ROW_DATA, 8'h34, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  8'h20, 1'b0, 1'b0, 8'h00},  // exactly the maximum
            '{ROW_DATA, 8'h7F, 1'b1, 1'b0, 8'h00},
            '{ROW_CFG,  8'h01, 1'b0, 1'b0, 8'h00},
            '{ROW_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
            '{ROW_DATA, 8'h00, 1'b1, 1'b1, 8'h00},
            '{ROW_CFG,  8'h02, 1'b0, 1'b0, 8'h00},
            '{ROW_DATA, 8'hC3, 1'b1, 1'b0, 8'h00}
        };

        rs_build_generator(RSP_CFG_W'(RESET_COUNT));
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        for (r = 0; r < N_ROWS; r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_parity_count(dir_rows[r].value[RSP_CFG_W-1:0]);
            else
                send_byte(dir_rows[r].value, dir_rows[r].eom,
                          dir_rows[r].typed, dir_rows[r].typed_val);
        end

        // random phases: a count write, then a few messages; now and then one is cut short
        while (beats_sent < ITEMS_TOTAL)
        begin
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = '1;
                2:       v = RSP_CFG_W'(RSP_MAX_PARITY);
                3:       v = RSP_CFG_W'($urandom_range(RSP_MAX_PARITY + 1, 63));
                4:       v = RSP_CFG_W'($urandom_range(0, 63));
                default: v = RSP_CFG_W'($urandom_range(1, 12));
            endcase
            write_parity_count(v);
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            n_msgs = $urandom_range(1, 4);
            for (m = 0; m < n_msgs; m++)
            begin
                len    = $urandom_range(1, 12);
                broken = (m == n_msgs - 1) && ($urandom_range(0, 7) == 0);
                for (k = 0; k < len; k++)
                begin
                    case ($urandom_range(0, 7))
                        0:       b = 8'h00;
                        1:       b = 8'hFF;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    send_byte(b, (k == len - 1) && !broken, 1'b0, 8'h00);
                end
            end
        end

        data_valid <= 1'b0;
        while (parity_due.size() != 0) @(posedge clk);
        // last parity beat is out; give any stray beat a chance to show up
        repeat (40) @(posedge clk);

        r = 0;
        for (k = 1; k <= RSP_MAX_PARITY; k++)
            if (deg_seen[k])
                r++;
        $display("run covered %0d data beats in %0d closed blocks, %0d parity beats checked",
                 beats_sent, blocks_sent, parity_checked);
        $display("%0d count writes reached %0d distinct degrees, %0d mismatches",
                 cfg_writes, r, mismatches);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("timeout with %0d parity beats still due", parity_due.size());
        $display("tb failed");
        $finish;
    end

endmodule
